@@ rtl/sffc_pkg.sv @@
// Shared types and constants for the small float format converter.
package sffc_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ModeWidth = 3;

   localparam logic [ModeWidth-1:0] MODE_H2S  = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_S2H  = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_BF2S = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_S2BF = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_F242S = 3'd4;
   localparam logic [ModeWidth-1:0] MODE_S2F24 = 3'd5;

   localparam logic [4:0]  HALF_EXP_MAX   = 5'h1F;
   localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;
   localparam logic [7:0]  HALF_BIAS_ADJ  = 8'd112;
   localparam logic [7:0]  HALF_SUB_ADJ   = 8'd103;
   localparam logic [7:0]  HALF_BIG_EXP   = 8'd143;
   localparam logic [7:0]  HALF_TINY_EXP  = 8'd102;
   localparam logic [7:0]  HALF_SUB_TOP   = 8'd112;
   localparam logic [7:0]  HALF_SUB_SHIFT = 8'd125;
   localparam logic [14:0] HALF_INF_BODY  = 15'h7C00;
   localparam logic [31:0] HALF_QNAN      = 32'h0000_7FFF;
   localparam logic [15:0] BF16_QUIET     = 16'h0040;
   localparam logic [23:0] F24_QUIET      = 24'h00_4000;

   typedef enum logic [1:0] {
      H_ZERO,
      H_SUB,
      H_NORM,
      H_SPECIAL
   } h_cls_type;

   typedef enum logic [2:0] {
      S_NAN,
      S_BIG,
      S_TINY,
      S_SUB,
      S_NORM
   } s_cls_type;

   typedef struct packed {
      logic                 valid;
      logic [ModeWidth-1:0] mode;
      logic [WordWidth-1:0] bits;
      h_cls_type            h_cls;
      logic [7:0]           h_exp;
      logic [3:0]           h_shift;
      s_cls_type            s_cls;
      logic [4:0]           s_shift;
      logic [4:0]           s_exp;
      logic                 nan;
   } dec_type;

   typedef struct packed {
      logic                 valid;
      logic [ModeWidth-1:0] mode;
      logic [WordWidth-1:0] bits;
      s_cls_type            s_cls;
      logic [4:0]           s_exp;
      logic [10:0]          t;
      logic [10:0]          nm;
      logic                 nan;
      logic [WordWidth-1:0] h2s_word;
   } align_type;

endpackage

@@ rtl/sffc_decode.sv @@
// First stage: field split, classification and leading-one search.
module sffc_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sffc_pkg::ModeWidth-1:0]    req_mode,
   input  logic [sffc_pkg::WordWidth-1:0]    req_in_bits,
   output sffc_pkg::dec_type                 dec_o
);
   import sffc_pkg::*;

   dec_type    dec_in;
   dec_type    dec_ff;
   logic [4:0] h_e;
   logic [9:0] h_m;
   logic [3:0] p;
   logic [7:0] be;
   logic [22:0] sm;
   logic [7:0] sub_shift;
   logic [7:0] norm_exp;

   always_comb begin
      h_e = req_in_bits[14:10];
      h_m = req_in_bits[9:0];
      be  = req_in_bits[30:23];
      sm  = req_in_bits[22:0];

      // The highest set bit of the half mantissa wins.
      p = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h_m[i]) begin
            p = 4'(i);
         end
      end

      dec_in       = '0;
      dec_in.valid = start;
      dec_in.mode  = req_mode;
      dec_in.bits  = req_in_bits;

      if (h_e == HALF_EXP_MAX) begin
         dec_in.h_cls = H_SPECIAL;
         dec_in.h_exp = SINGLE_EXP_MAX;
      end else if (h_e != 5'd0) begin
         dec_in.h_cls = H_NORM;
         dec_in.h_exp = {3'b000, h_e} + HALF_BIAS_ADJ;
      end else if (h_m != 10'd0) begin
         dec_in.h_cls = H_SUB;
         dec_in.h_exp = {4'b0000, p} + HALF_SUB_ADJ;
      end else begin
         dec_in.h_cls = H_ZERO;
         dec_in.h_exp = 8'd0;
      end
      dec_in.h_shift = 4'd10 - p;

      dec_in.nan = (be == SINGLE_EXP_MAX) && (sm != 23'd0);
      sub_shift  = HALF_SUB_SHIFT - be;
      norm_exp   = be - HALF_BIAS_ADJ;
      dec_in.s_shift = sub_shift[4:0];
      dec_in.s_exp   = norm_exp[4:0];
      if (dec_in.nan) begin
         dec_in.s_cls = S_NAN;
      end else if (be >= HALF_BIG_EXP) begin
         dec_in.s_cls = S_BIG;
      end else if (be < HALF_TINY_EXP) begin
         dec_in.s_cls = S_TINY;
      end else if (be <= HALF_SUB_TOP) begin
         dec_in.s_cls = S_SUB;
      end else begin
         dec_in.s_cls = S_NORM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else begin
         dec_ff.valid <= dec_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff.mode    <= dec_in.mode;
      dec_ff.bits    <= dec_in.bits;
      dec_ff.h_cls   <= dec_in.h_cls;
      dec_ff.h_exp   <= dec_in.h_exp;
      dec_ff.h_shift <= dec_in.h_shift;
      dec_ff.s_cls   <= dec_in.s_cls;
      dec_ff.s_shift <= dec_in.s_shift;
      dec_ff.s_exp   <= dec_in.s_exp;
      dec_ff.nan     <= dec_in.nan;
   end

   assign dec_o = dec_ff;

endmodule

@@ rtl/sffc_align.sv @@
// Second stage: mantissa shifts and the finished half to single word.
module sffc_align (
   input  logic                clock,
   input  logic                reset,
   input  sffc_pkg::dec_type   dec_i,
   output sffc_pkg::align_type aln_o
);
   import sffc_pkg::*;

   align_type   aln_in;
   align_type   aln_ff;
   logic [23:0] full;
   logic [23:0] t_wide;
   logic [19:0] hm_wide;
   logic [9:0]  h_m;
   logic        h_sign;

   always_comb begin
      h_m    = dec_i.bits[9:0];
      h_sign = dec_i.bits[15];
      full   = {1'b1, dec_i.bits[22:0]};
      // Keeping one extra bit below the result gives the round bit.
      t_wide  = full >> dec_i.s_shift;
      hm_wide = {10'd0, h_m} << dec_i.h_shift;

      aln_in       = '0;
      aln_in.valid = dec_i.valid;
      aln_in.mode  = dec_i.mode;
      aln_in.bits  = dec_i.bits;
      aln_in.s_cls = dec_i.s_cls;
      aln_in.s_exp = dec_i.s_exp;
      aln_in.nan   = dec_i.nan;
      aln_in.t     = t_wide[10:0];
      aln_in.nm    = {1'b0, dec_i.bits[22:13]} + {10'd0, dec_i.bits[12]};

      case (dec_i.h_cls)
         H_ZERO:  aln_in.h2s_word = {h_sign, 31'd0};
         H_SUB:   aln_in.h2s_word = {h_sign, dec_i.h_exp, hm_wide[9:0], 13'd0};
         default: aln_in.h2s_word = {h_sign, dec_i.h_exp, h_m, 13'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aln_ff.valid <= 1'b0;
      end else begin
         aln_ff.valid <= aln_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      aln_ff.mode     <= aln_in.mode;
      aln_ff.bits     <= aln_in.bits;
      aln_ff.s_cls    <= aln_in.s_cls;
      aln_ff.s_exp    <= aln_in.s_exp;
      aln_ff.t        <= aln_in.t;
      aln_ff.nm       <= aln_in.nm;
      aln_ff.nan      <= aln_in.nan;
      aln_ff.h2s_word <= aln_in.h2s_word;
   end

   assign aln_o = aln_ff;

endmodule

@@ rtl/sffc_round.sv @@
// Third stage: rounding adds, result select and the output register.
module sffc_round (
   input  logic                           clock,
   input  logic                           reset,
   input  sffc_pkg::align_type            aln_i,
   output logic                           rsp_strobe,
   output logic [sffc_pkg::WordWidth-1:0] rsp_out_bits
);
   import sffc_pkg::*;

   logic                 rsp_strobe_ff;
   logic                 rsp_strobe_in;
   logic [WordWidth-1:0] rsp_out_bits_ff;
   logic [WordWidth-1:0] rsp_out_bits_in;
   logic [10:0]          sub_sum;
   logic [14:0]          body;
   logic [15:0]          bf_sum;
   logic [23:0]          f24_sum;
   logic                 sign;

   always_comb begin
      sign    = aln_i.bits[31];
      sub_sum = {1'b0, aln_i.t[10:1]} + {10'd0, aln_i.t[0]};
      case (aln_i.s_cls)
         S_BIG:   body = HALF_INF_BODY;
         S_SUB:   body = {4'd0, sub_sum};
         S_NORM:  body = {aln_i.s_exp, 10'd0} + {4'd0, aln_i.nm};
         default: body = 15'd0;
      endcase

      // A carry out of the top wraps away, as the narrow word is masked.
      bf_sum  = aln_i.bits[31:16] + {15'd0, aln_i.bits[15]};
      f24_sum = aln_i.bits[31:8] + {23'd0, aln_i.bits[7]};

      rsp_strobe_in = aln_i.valid;
      case (aln_i.mode)
         MODE_H2S: rsp_out_bits_in = aln_i.h2s_word;
         MODE_S2H: begin
            if (aln_i.s_cls == S_NAN) begin
               rsp_out_bits_in = HALF_QNAN;
            end else begin
               rsp_out_bits_in = {16'd0, sign, body};
            end
         end
         MODE_BF2S: rsp_out_bits_in = {aln_i.bits[15:0], 16'd0};
         MODE_S2BF: begin
            if (aln_i.nan) begin
               rsp_out_bits_in = {16'd0, aln_i.bits[31:16] | BF16_QUIET};
            end else begin
               rsp_out_bits_in = {16'd0, bf_sum};
            end
         end
         MODE_F242S: rsp_out_bits_in = {aln_i.bits[23:0], 8'd0};
         MODE_S2F24: begin
            if (aln_i.nan) begin
               rsp_out_bits_in = {8'd0, aln_i.bits[31:8] | F24_QUIET};
            end else begin
               rsp_out_bits_in = {8'd0, f24_sum};
            end
         end
         default: rsp_out_bits_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_bits_ff <= rsp_out_bits_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_out_bits = rsp_out_bits_ff;

endmodule

@@ rtl/small_float_format_converter_top.sv @@
// Top level of the small float format converter: three-stage conversion pipeline.
//
// Converts one 32-bit word per beat between IEEE single and half, bfloat16
// or a 24-bit truncated single, chosen by req_mode. A beat is taken at every
// clock edge where start is high; busy is always low, so a new beat may
// follow in every cycle. Each result appears on rsp_out_bits with rsp_strobe
// high for one cycle, in order, once its start beat has passed through
// the three pipeline registers (decode, align, round) in turn;
// the result is not held, so the receiver must take it in that cycle.
module small_float_format_converter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sffc_pkg::ModeWidth-1:0] req_mode,
   input  logic [sffc_pkg::WordWidth-1:0] req_in_bits,
   output logic                           rsp_strobe,
   output logic [sffc_pkg::WordWidth-1:0] rsp_out_bits
);
   import sffc_pkg::*;

   dec_type   dec;
   align_type aln;

   assign busy = 1'b0;

   sffc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_mode    (req_mode),
      .req_in_bits (req_in_bits),
      .dec_o       (dec)
   );

   sffc_align u_align (
      .clock (clock),
      .reset (reset),
      .dec_i (dec),
      .aln_o (aln)
   );

   sffc_round u_round (
      .clock        (clock),
      .reset        (reset),
      .aln_i        (aln),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_bits (rsp_out_bits)
   );

endmodule

@@ dv/small_float_format_converter_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the small float format converter top level.
module small_float_format_converter_top_test;
   import sffc_pkg::*;

   localparam logic [ModeWidth-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [ModeWidth-1:0] MODE_SPARE_B = 3'd7;
   localparam logic [ModeWidth-1:0] LIVE_MODES [6] = '{
      MODE_H2S, MODE_S2H, MODE_BF2S, MODE_S2BF, MODE_F242S, MODE_S2F24
   };
   localparam int RANDOM_WORDS = 1600;
   localparam int IDLE_LIMIT = 200;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic [WordWidth-1:0] bits;
   } conv_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ModeWidth-1:0] req_mode = '0;
   logic [WordWidth-1:0] req_in_bits = '0;
   logic                 rsp_strobe;
   logic [WordWidth-1:0] rsp_out_bits;

   conv_req_type         pending_words[$];
   logic [WordWidth-1:0] words_due[$];
   int                   words_queued = 0;
   int                   beats_taken = 0;
   int                   results_seen = 0;
   int                   fails = 0;
   int                   idle_cycles = 0;
   int                   mode_seen [8] = '{default: 0};
   logic                 beat_taken = 1'b0;
   int                   gap_left = 0;
   logic                 burst = 1'b0;

   small_float_format_converter_top u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_in_bits  (req_in_bits),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_bits (rsp_out_bits)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] man;
      logic [7:0] se;
      int         p;
      ex = h[14:10];
      man = h[9:0];
      if (ex == 5'h1F) begin
         se = 8'hFF;
      end else if (ex == 5'h00) begin
         if (man == 10'd0) return {h[15], 31'b0};
         // Renormalize the subnormal around its leading one.
         p = 9;
         while (!man[p]) p--;
         se = 8'(p + 103);
         man = 10'(man << (10 - p));
      end else begin
         se = {3'b000, ex} + 8'd112;
      end
      return {h[15], se, man, 13'b0};
   endfunction

   function automatic logic [15:0] narrow_to_half(logic [31:0] x);
      logic [7:0]  be;
      logic [22:0] man;
      logic [23:0] full;
      logic [31:0] body;
      int          ex;
      int          s;
      be = x[30:23];
      man = x[22:0];
      ex = int'(be) - 127;
      if (be == 8'hFF && man != 23'd0) return 16'h7FFF;
      if (ex >= 16) begin
         body = 32'h7C00;
      end else if (ex < -25) begin
         body = 32'd0;
      end else if (ex < -14) begin
         s = -1 - ex;
         full = {1'b1, man};
         body = 32'(full >> s) + 32'(full[s-1]);
      end else begin
         body = 32'((ex + 15) << 10) + 32'(man >> 13) + 32'(man[12]);
      end
      return 16'({16'd0, x[31], 15'd0} | body);
   endfunction

   // Ties round away from zero; a NaN is cut short and kept quiet instead.
   function automatic logic [31:0] cut_single(logic [31:0] x, int drop, logic [31:0] quiet);
      if (x[30:23] == 8'hFF && x[22:0] != 23'd0) return (x >> drop) | quiet;
      return (x >> drop) + 32'(x[drop-1]);
   endfunction

   function automatic logic [31:0] convert_word(logic [ModeWidth-1:0] mode, logic [31:0] x);
      case (mode)
         MODE_H2S:   return widen_half(x[15:0]);
         MODE_S2H:   return {16'd0, narrow_to_half(x)};
         MODE_BF2S:  return {x[15:0], 16'd0};
         MODE_S2BF:  return cut_single(x, 16, {16'd0, BF16_QUIET}) & 32'h0000_FFFF;
         MODE_F242S: return {x[23:0], 8'd0};
         MODE_S2F24: return cut_single(x, 8, {8'd0, F24_QUIET}) & 32'h00FF_FFFF;
         default:    return 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] pick_bits(logic [ModeWidth-1:0] mode);
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 3))
         1: begin
            if (mode == MODE_H2S) begin
               w[14:10] = $urandom_range(0, 1) ? 5'h1F : 5'h00;
            end else if (mode == MODE_S2H) begin
               w[30:23] = 8'($urandom_range(100, 145));
            end else begin
               w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
         end
         2: begin
            // In the narrowing modes the dropped bits sit at or just under the halfway point.
            if (mode == MODE_S2H) begin
               w[30:23] = 8'($urandom_range(100, 145));
               w[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
               if ($urandom_range(0, 1)) w[22:13] = '1;
            end else if (mode == MODE_S2BF) begin
               w[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
               if ($urandom_range(0, 1)) w[22:16] = '1;
            end else if (mode == MODE_S2F24) begin
               w[7:0] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
               if ($urandom_range(0, 1)) w[22:8] = '1;
            end else begin
               w[9:0] = '1;
            end
         end
         3: begin
            // Near the top of the range, where rounding can carry to infinity.
            w[30:23] = (mode == MODE_S2H) ? 8'd142 : ($urandom_range(0, 1) ? 8'hFE : 8'hFF);
            w[22:0] = ~23'($urandom_range(0, 255));
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic queue_word(logic [ModeWidth-1:0] mode, logic [31:0] bits);
      pending_words.push_back('{mode: mode, bits: bits});
      words_queued++;
   endtask

   // Driver: one item per start beat, with a random gap after each, none in a burst.
   always @(negedge clock) begin
      conv_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            nxt = pending_words.pop_front();
            start <= 1'b1;
            req_mode <= nxt.mode;
            req_in_bits <= nxt.bits;
            if ($urandom_range(0, 39) == 0) burst <= !burst;
            gap_left <= burst ? 0 : $urandom_range(0, 8);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each accepted beat and checks each result beat.
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         beat_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         beat_taken <= start && !busy;
         if (rsp_strobe) begin
            results_seen++;
            if (words_due.size() == 0) begin
               $error("out_bits: expected no result, actual %h", rsp_out_bits);
               fails++;
            end else begin
               want = words_due.pop_front();
               if (rsp_out_bits !== want) begin
                  $error("out_bits: expected %h, actual %h", want, rsp_out_bits);
                  fails++;
               end
            end
         end
         if (start && !busy) begin
            words_due.push_back(convert_word(req_mode, req_in_bits));
            mode_seen[req_mode]++;
            beats_taken++;
         end
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [ModeWidth-1:0] m;
      queue_word(MODE_H2S, 32'h0000_0000);
      queue_word(MODE_H2S, 32'h0000_8001);
      queue_word(MODE_H2S, 32'h0000_03FF);
      queue_word(MODE_H2S, 32'h0000_7BFF);
      queue_word(MODE_H2S, 32'h0000_FC00);
      queue_word(MODE_H2S, 32'hFFFF_FFFF);
      queue_word(MODE_S2H, 32'h7FC0_0000);
      queue_word(MODE_S2H, 32'hFF80_0000);
      queue_word(MODE_S2H, 32'h4780_0000);
      queue_word(MODE_S2H, 32'h477F_F000);
      queue_word(MODE_S2H, 32'h3300_0000);
      queue_word(MODE_S2H, 32'hB2FF_FFFF);
      queue_word(MODE_S2H, 32'h387F_E000);
      queue_word(MODE_S2H, 32'h8000_0001);
      queue_word(MODE_S2H, 32'h3F80_1000);
      queue_word(MODE_BF2S, 32'hFFFF_FFFF);
      queue_word(MODE_S2BF, 32'h7F7F_8000);
      queue_word(MODE_S2BF, 32'hFF81_0000);
      queue_word(MODE_S2BF, 32'h3F80_8000);
      queue_word(MODE_F242S, 32'hFFFF_FFFF);
      queue_word(MODE_S2F24, 32'hFF7F_FF80);
      queue_word(MODE_S2F24, 32'h7F80_0001);
      queue_word(MODE_S2F24, 32'h0000_0080);
      queue_word(MODE_SPARE_A, 32'hFFFF_FFFF);
      queue_word(MODE_SPARE_B, 32'hFFFF_FFFF);
      repeat (RANDOM_WORDS) begin
         if ($urandom_range(0, 49) == 0) m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
         else m = LIVE_MODES[$urandom_range(0, 5)];
         queue_word(m, pick_bits(m));
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_taken < words_queued || words_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Converted %0d words, %0d results checked, %0d mismatches.",
               beats_taken, results_seen, fails);
      $display("Per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", mode_seen[0], mode_seen[1],
               mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5], mode_seen[6],
               mode_seen[7]);
      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sffc_pkg.sv
rtl/sffc_decode.sv
rtl/sffc_align.sv
rtl/sffc_round.sv
rtl/small_float_format_converter_top.sv
dv/small_float_format_converter_top_test.sv
